/* rtl/psrw_pkg.sv */
// ----------------------------------------------------------------------------
// psrw_pkg: shared types and constants
// Payload structs, queue entry, back-end states and the fixed words and masks
// of the synthesizer register word generator.
// ----------------------------------------------------------------------------
package psrw_pkg;

  localparam int unsigned FREQ_W = 23;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned QUOT_W = 6;
  localparam int unsigned REM_W  = 17;
  localparam int unsigned FRAC_W = 12;

  // Request codes of the command channel. Request code 3 has no function;
  // it is accepted and dropped.
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_FREQ  = 2'd1;
  localparam logic [1:0] REQ_AMP   = 2'd2;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  localparam logic [WORD_W-1:0] SHADOW_DEFAULT = 32'h00CC_803C;
  localparam logic [WORD_W-1:0] DIV_CLEAR_MASK = 32'hFF8F_FFFF;
  localparam logic [WORD_W-1:0] AMP_CLEAR_MASK = 32'hFFFF_FFE7;
  localparam logic [WORD_W-1:0] R0_MASK        = 32'h07FF_FFF8;

  localparam logic [FREQ_W-1:0] PFD_KHZ    = 23'd100000;
  localparam logic [FREQ_W-1:0] FREQ_MIN   = 23'd34375;
  localparam logic [FREQ_W-1:0] FREQ_LIMIT = 23'd4400000;

  // Reciprocal of 100000 scaled by 2**40 and rounded up. It gives the exact
  // quotient for every dividend below 2**23.
  localparam int unsigned       RECIP_W     = 24;
  localparam int unsigned       RECIP_SHIFT = 40;
  localparam logic [RECIP_W-1:0] PFD_RECIP  = 24'd10995117;

  localparam int unsigned INIT_LEN = 6;
  localparam logic [WORD_W-1:0] INIT_WORDS [INIT_LEN] = '{
    32'h002C_0010, 32'h0800_E1A9, 32'h1800_4E42,
    32'h0000_04B3, 32'h00CC_803C, 32'h0058_0005
  };

  typedef struct packed {
    logic [1:0]        req_type;
    logic [FREQ_W-1:0] freq_khz;
    logic [1:0]        amp_level;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0] reg_word;
    logic              last;
    logic              range_error;
  } word_t;

  typedef enum logic [1:0] {
    OP_INIT,
    OP_FREQ,
    OP_AMP,
    OP_ERR
  } op_e;

  // One classified command waiting for the back end.
  typedef struct packed {
    op_e               op;
    logic [2:0]        div_code;
    logic [FREQ_W-1:0] prod;
    logic [1:0]        amp;
  } job_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [REM_W-1:0]  rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_R4,
    ST_R0,
    ST_AMP,
    ST_ERR
  } back_state_e;

endpackage

/* rtl/psrw_if.sv */
// ----------------------------------------------------------------------------
// psrw_if: stream interfaces
// Valid/ready channels for commands and for generated control words.
// ----------------------------------------------------------------------------
interface psrw_cmd_if;
  import psrw_pkg::*;

  logic valid;
  logic ready;
  cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface psrw_word_if;
  import psrw_pkg::*;

  logic  valid;
  logic  ready;
  word_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/psrw_front.sv */
// ----------------------------------------------------------------------------
// psrw_front: command classifier
// Accepts commands, picks the output divider band and queues a job.
// ----------------------------------------------------------------------------
module psrw_front (
  psrw_cmd_if.sink        cmd_i,
  input  logic            q_full_i,
  output logic            push_o,
  output psrw_pkg::job_t  job_o
);
  import psrw_pkg::*;

  logic [2:0] code;
  logic       in_range;

  assign cmd_i.ready = !q_full_i;

  // Unused request codes are taken and dropped.
  assign push_o = cmd_i.valid && !q_full_i && (cmd_i.payload.req_type != REQ_SPARE);

  assign in_range = (cmd_i.payload.freq_khz >= FREQ_MIN) &&
                    (cmd_i.payload.freq_khz < FREQ_LIMIT);

  // The divider is 2**code, so the code doubles as the shift amount.
  always_comb begin
    if (cmd_i.payload.freq_khz < 23'd68750) begin
      code = 3'd6;
    end else if (cmd_i.payload.freq_khz < 23'd137500) begin
      code = 3'd5;
    end else if (cmd_i.payload.freq_khz < 23'd275000) begin
      code = 3'd4;
    end else if (cmd_i.payload.freq_khz < 23'd550000) begin
      code = 3'd3;
    end else if (cmd_i.payload.freq_khz < 23'd1100000) begin
      code = 3'd2;
    end else if (cmd_i.payload.freq_khz < 23'd2200000) begin
      code = 3'd1;
    end else begin
      code = 3'd0;
    end
  end

  always_comb begin
    job_o.div_code = code;
    job_o.prod     = cmd_i.payload.freq_khz << code;
    job_o.amp      = cmd_i.payload.amp_level;
    unique case (cmd_i.payload.req_type)
      REQ_INIT: job_o.op = OP_INIT;
      REQ_FREQ: job_o.op = in_range ? OP_FREQ : OP_ERR;
      REQ_AMP:  job_o.op = OP_AMP;
      default:  job_o.op = OP_ERR;
    endcase
  end

endmodule

/* rtl/psrw_fifo.sv */
// ----------------------------------------------------------------------------
// psrw_fifo: job queue
// Short first-in first-out queue between the classifier and the back end.
// ----------------------------------------------------------------------------
module psrw_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  psrw_pkg::job_t wr_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           rd_valid_o,
  output psrw_pkg::job_t rd_data_o
);
  import psrw_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/psrw_div.sv */
// ----------------------------------------------------------------------------
// psrw_div: divide by the reference frequency
// Quotient of the product by 100000 from a reciprocal multiplication, then the
// remainder from a multiply-back, one step per cycle.
// ----------------------------------------------------------------------------
module psrw_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psrw_pkg::div_req_t req_i,
  output psrw_pkg::div_rsp_t rsp_o
);
  import psrw_pkg::*;

  localparam int unsigned PROD_W = FREQ_W + RECIP_W;

  logic              busy_q, rem_pend_q, done_q;
  logic [FREQ_W-1:0] dvd_q;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W-1:0]  rem_q;
  logic [PROD_W-1:0] recip_prod;
  logic [FREQ_W-1:0] quot_scaled;
  logic [FREQ_W-1:0] rem_full;

  assign recip_prod  = PROD_W'(dvd_q) * PROD_W'(PFD_RECIP);
  assign quot_scaled = FREQ_W'(quot_q) * PFD_KHZ;
  assign rem_full    = dvd_q - quot_scaled;

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      rem_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else if (req_i.start) begin
      busy_q     <= 1'b1;
      rem_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      rem_pend_q <= busy_q;
      if (rem_pend_q) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
    end
    if (busy_q) begin
      quot_q <= recip_prod[RECIP_SHIFT +: QUOT_W];
    end
    if (rem_pend_q) begin
      rem_q <= rem_full[REM_W-1:0];
    end
  end

endmodule

/* rtl/psrw_back.sv */
// ----------------------------------------------------------------------------
// psrw_back: word sequencer
// Takes queued jobs, keeps the register 4 shadow and emits the control words.
// ----------------------------------------------------------------------------
module psrw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  psrw_pkg::job_t     job_i,
  output logic               pop_o,
  output psrw_pkg::div_req_t div_req_o,
  input  psrw_pkg::div_rsp_t div_rsp_i,
  psrw_word_if.source        word_o
);
  import psrw_pkg::*;

  back_state_e       state_q, state_d;
  job_t              job_q, job_d;
  logic [2:0]        idx_q, idx_d;
  logic              rep_q, rep_d;
  logic [WORD_W-1:0] shadow_q, shadow_d;
  logic              out_valid_q;
  word_t             out_q, out_d;
  logic              out_load, out_free;
  logic [WORD_W-1:0] r4_div, r4_amp, r0_word;
  logic [FRAC_W-1:0] frac;

  assign out_free = !out_valid_q || word_o.ready;

  // The fraction scale 3125/100000 is exactly 1/32.
  assign frac    = div_rsp_i.rem[REM_W-1:REM_W-FRAC_W];
  assign r4_div  = (shadow_q & DIV_CLEAR_MASK) | (WORD_W'(job_q.div_code) << 20);
  assign r4_amp  = (shadow_q & AMP_CLEAR_MASK) | (WORD_W'(job_q.amp) << 3);
  assign r0_word = ((WORD_W'(div_rsp_i.quot) << 15) | (WORD_W'(frac) << 3)) & R0_MASK;

  always_comb begin
    state_d            = state_q;
    job_d              = job_q;
    idx_d              = idx_q;
    rep_d              = rep_q;
    shadow_d           = shadow_q;
    pop_o              = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = job_i.prod;
    out_load           = 1'b0;
    out_d              = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          job_d = job_i;
          idx_d = '0;
          rep_d = 1'b0;
          unique case (job_i.op)
            OP_INIT: state_d = ST_INIT;
            OP_FREQ: begin
              div_req_o.start = 1'b1;
              state_d         = ST_R4;
            end
            OP_AMP:  state_d = ST_AMP;
            OP_ERR:  state_d = ST_ERR;
            default: state_d = ST_ERR;
          endcase
        end
      end
      ST_INIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.reg_word = INIT_WORDS[idx_q];
          out_d.last     = rep_q && (idx_q == 3'(INIT_LEN - 1));
          if (idx_q == 3'(INIT_LEN - 1)) begin
            idx_d = '0;
            rep_d = 1'b1;
            if (rep_q) begin
              shadow_d = SHADOW_DEFAULT;
              state_d  = ST_IDLE;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_R4: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.reg_word = r4_div;
          shadow_d       = r4_div;
          state_d        = ST_R0;
        end
      end
      ST_R0: begin
        if (out_free && div_rsp_i.done) begin
          out_load       = 1'b1;
          out_d.reg_word = r0_word;
          out_d.last     = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_AMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_d.reg_word = r4_amp;
          out_d.last     = 1'b1;
          shadow_d       = r4_amp;
          state_d        = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_d.last        = 1'b1;
          out_d.range_error = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      rep_q       <= 1'b0;
      shadow_q    <= SHADOW_DEFAULT;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      rep_q    <= rep_d;
      shadow_q <= shadow_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (word_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign word_o.valid   = out_valid_q;
  assign word_o.payload = out_q;

endmodule

/* rtl/pll_synth_register_word_gen.sv */
// ----------------------------------------------------------------------------
// pll_synth_register_word_gen: synthesizer control word generator
// Turns init, set-frequency and set-amplitude commands into the 32-bit words
// that program a fractional-N synthesizer.
// ----------------------------------------------------------------------------
// Each command arrives as one transfer on cmd_i and leaves as a run of words
// on word_o, the final word flagged by last. Init sends the six default words
// twice (twelve words) and reloads the register 4 shadow. Set frequency sends
// the updated register 4 word and then register 0 with INT and FRAC; a
// frequency outside 34375 to 4399999 kHz yields a single zero word with
// range_error set and leaves the shadow alone. Set amplitude sends one
// register 4 word. Request code 3 is taken and produces nothing. Commands go
// through a queue of FIFO_DEPTH entries, so the command side takes one
// transfer per cycle while words drain, until the queue fills. The back end
// takes a job from the queue in its idle state and then emits at most one
// word per cycle. In a frequency run the divide-by-100000 unit forms the
// quotient by a reciprocal multiplication in the cycle after the job is taken
// and the remainder in the next, and register 0 waits for the divider's done
// flag after the register 4 word. A stalled word_o holds its word in the
// output register and stalls the sequencer behind it.
module pll_synth_register_word_gen #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  psrw_cmd_if.sink     cmd_i,
  psrw_word_if.source  word_o
);
  import psrw_pkg::*;

  logic     push, pop, q_full, q_valid;
  job_t     push_job, head_job;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // Classification of each command into a queued job.
  psrw_front u_front (
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (push_job)
  );

  psrw_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wr_data_i  (push_job),
    .pop_i      (pop),
    .full_o     (q_full),
    .rd_valid_o (q_valid),
    .rd_data_o  (head_job)
  );

  // The divider is started as a frequency job leaves the queue.
  psrw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  psrw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .word_o      (word_o)
  );

endmodule

/* rtl/psrw_checker.sv */
// ----------------------------------------------------------------------------
// psrw_checker: port checks
// Assertions on the word channel of the control word generator.
// ----------------------------------------------------------------------------
module psrw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        word_valid_i,
  input logic        word_ready_i,
  input logic [31:0] reg_word_i,
  input logic        last_i,
  input logic        range_error_i
);

  // A stalled word must hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_i && !word_ready_i |=> word_valid_i && $stable(reg_word_i) &&
    $stable(last_i) && $stable(range_error_i))
    else $error("stalled word changed");

  // An error result is a lone zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_i && range_error_i |-> last_i && (reg_word_i == 32'd0))
    else $error("malformed range error word");

  // Only the final word of a run may carry an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_valid_i && !last_i |-> !range_error_i)
    else $error("error flag on a non-final word");

  // Once reset has been seen at an edge, no word is offered at the next one.
  assert property (@(posedge clk_i) !rst_ni |=> !word_valid_i)
    else $error("word offered during reset");

endmodule

bind pll_synth_register_word_gen psrw_checker u_psrw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .word_valid_i  (word_o.valid),
  .word_ready_i  (word_o.ready),
  .reg_word_i    (word_o.payload.reg_word),
  .last_i        (word_o.payload.last),
  .range_error_i (word_o.payload.range_error)
);
